### hdl/hti_pkg.sv
// Shared types and constants for the heightmap triangle interpolation block.
// Used by the controller, the datapath and the top level; depends on nothing.
package hti_pkg;

  // corner read selects
  localparam logic [1:0] CORNER_BASE = 2'd0;  // h1 in the lower triangle, h3 in the upper
  localparam logic [1:0] CORNER_H0   = 2'd1;
  localparam logic [1:0] CORNER_H2   = 2'd2;

  typedef struct packed {
    logic       load;       // latch the accepted input word
    logic       wr_en;      // store the latched height
    logic       calc_addr;  // range check, cell base address, triangle select
    logic [1:0] rd_sel;     // corner to read this cycle
    logic       cap_hb;     // capture base corner from read data
    logic       cap_h0;     // capture h0 from read data
    logic       mul_a;      // first weighted difference
    logic       mul_b;      // second weighted difference
    logic       sum;        // accumulate, round, saturate into output register
  } cmd_t;

  typedef struct packed {
    logic query_in;  // word on the input port is a query
    logic on_grid;   // latched position lies on the grid
  } sts_t;

endpackage

### hdl/hti_ctrl.sv
// Sequencer for the heightmap lookup: issues datapath commands per word.
// Depends on hti_pkg.
module hti_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  hti_pkg::sts_t sts,
  output hti_pkg::cmd_t cmd
);
  import hti_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_ADDR = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_MULA = 4'd6;
  localparam logic [3:0] S_MULB = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = CORNER_BASE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.query_in ? S_ADDR : S_WR;
        end
      end
      S_WR: begin
        cmd.wr_en  = 1'b1;
        state_next = S_IDLE;
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_next    = sts.on_grid ? S_RD0 : S_OUT;
      end
      S_RD0: begin
        cmd.rd_sel = CORNER_BASE;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_sel = CORNER_H0;
        cmd.cap_hb = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_sel = CORNER_H2;
        cmd.cap_h0 = 1'b1;
        state_next = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/hti_dp.sv
// Datapath: height memory, cell addressing, shared multiplier, rounding.
// Depends on hti_pkg; driven by hti_ctrl commands.
module hti_dp #(
  parameter int MAX_CELLS = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  input  logic               mode,
  input  logic [12:0]        point_index,
  input  logic signed [15:0] height_value,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_z,
  input  hti_pkg::cmd_t      cmd,
  output hti_pkg::sts_t      sts,
  output logic signed [15:0] height_out,
  output logic               in_range
);
  import hti_pkg::*;

  localparam int DEPTH = (MAX_CELLS + 1) * (MAX_CELLS + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_CELLS + 2);
  localparam int PW    = 17 + FRAC_BITS + 2;
  localparam int SUMW  = 16 + FRAC_BITS + 3;
  localparam int HALF  = 1 << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [6:0]              cell_cfg;
  logic [12:0]             idx_q;
  logic signed [15:0]      val_q;
  logic signed [15:0]      x_q;
  logic signed [15:0]      z_q;
  logic [AW-1:0]           base_q;
  logic [AW-1:0]           stride_q;
  logic                    upper_q;
  logic [AW-1:0]           raddr;
  logic signed [15:0]      rdata;
  logic signed [15:0]      hb_q;
  logic signed [15:0]      h0_q;
  logic signed [15:0]      h2_q;
  logic signed [PW-1:0]    prod_a;
  logic signed [PW-1:0]    prod_b;
  logic signed [15:0]      mem [DEPTH];

  logic [CW-1:0]           cells;
  logic [16:0]             ix;
  logic [16:0]             iz;
  logic                    on_grid;
  logic [FRAC_BITS-1:0]    fx;
  logic [FRAC_BITS-1:0]    fz;
  logic [FRAC_BITS:0]      wa;
  logic [FRAC_BITS:0]      wb;
  logic signed [16:0]      da;
  logic signed [16:0]      db;
  logic signed [16:0]      mul_d;
  logic [FRAC_BITS:0]      mul_w;
  logic signed [PW-1:0]    prod;
  logic signed [SUMW-1:0]  s;
  logic signed [SUMW-1:0]  r;
  logic                    wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_cfg <= 7'd64;
    end else if (cfg_we) begin
      cell_cfg <= cfg_data;
    end
  end

  assign cells = (32'(cell_cfg) > 32'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(cell_cfg);

  // integer parts of the latched position, zero-extended
  assign ix      = {1'b0, x_q} >> FRAC_BITS;
  assign iz      = {1'b0, z_q} >> FRAC_BITS;
  assign on_grid = !x_q[15] && !z_q[15] && (ix < 17'(cells)) && (iz < 17'(cells));
  assign fx      = x_q[FRAC_BITS-1:0];
  assign fz      = z_q[FRAC_BITS-1:0];

  assign sts.query_in = mode;
  assign sts.on_grid  = on_grid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q <= point_index;
      val_q <= height_value;
      x_q   <= pos_x;
      z_q   <= pos_z;
    end
    if (cmd.calc_addr) begin
      stride_q <= AW'(cells) + AW'(1);
      base_q   <= AW'(iz) * (AW'(cells) + AW'(1)) + AW'(ix);
      upper_q  <= ({1'b0, fx} + {1'b0, fz}) >= ONE;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      CORNER_BASE: raddr = upper_q ? base_q + AW'(1) : base_q + stride_q;
      CORNER_H0:   raddr = base_q;
      CORNER_H2:   raddr = base_q + stride_q + AW'(1);
      default:     raddr = base_q;
    endcase
  end

  assign wr_ok = 32'(idx_q) < 32'(DEPTH);

  // single port: write or read in a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      if (wr_ok) begin
        mem[AW'(idx_q)] <= val_q;
      end
    end else begin
      rdata <= mem[raddr];
    end
  end

  // lower: base h1, (h0-h1)*fz + (h2-h1)*fx
  // upper: base h3, (h2-h3)*(1-fz) + (h0-h3)*(1-fx)
  assign da = upper_q ? 17'(rdata) - 17'(hb_q) : 17'(h0_q) - 17'(hb_q);
  assign db = upper_q ? 17'(h0_q) - 17'(hb_q) : 17'(h2_q) - 17'(hb_q);
  assign wa = upper_q ? ONE - {1'b0, fz} : {1'b0, fz};
  assign wb = upper_q ? ONE - {1'b0, fx} : {1'b0, fx};

  // one multiplier, first term then second term
  assign mul_d = cmd.mul_b ? db : da;
  assign mul_w = cmd.mul_b ? wb : wa;
  assign prod  = PW'(mul_d) * PW'($signed({1'b0, mul_w}));

  always_ff @(posedge clk) begin
    if (cmd.cap_hb) begin
      hb_q <= rdata;
    end
    if (cmd.cap_h0) begin
      h0_q <= rdata;
    end
    if (cmd.mul_a) begin
      h2_q   <= rdata;
      prod_a <= prod;
    end
    if (cmd.mul_b) begin
      prod_b <= prod;
    end
  end

  assign s = (SUMW'(hb_q) <<< FRAC_BITS) + SUMW'(prod_a) + SUMW'(prod_b) + SUMW'(HALF);
  assign r = s >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_out <= '0;
      in_range   <= 1'b0;
    end else if (cmd.calc_addr && !on_grid) begin
      height_out <= '0;
      in_range   <= 1'b0;
    end else if (cmd.sum) begin
      in_range <= 1'b1;
      if (r > SUMW'(32767)) begin
        height_out <= 16'sh7fff;
      end else if (r < -SUMW'(32768)) begin
        height_out <= 16'sh8000;
      end else begin
        height_out <= 16'(r);
      end
    end
  end

endmodule

### hdl/heightmap_triangle_interpolation.sv
// Top level of the heightmap triangle interpolation block.
// Instantiates hti_ctrl and hti_dp; depends on hti_pkg.
//
// Keeps a (cells+1) x (cells+1) grid of signed fixed-point vertex heights in a
// single-port memory and answers height queries by interpolating over the
// lower or upper triangle of the addressed cell. A write word (mode 0) stores
// one height; a query word (mode 1) passes the address, read, multiply and
// sum states before its result word is offered (only the address state if
// off the grid), and the next word is taken the cycle after the result leaves.
// The query time is set by the three corner reads through the one memory port and the shared
// multiplier that forms the two weighted differences in turn. The memory is
// not cleared: heights read before they are written are undefined.
// cell_count must be written only while idle; the block does not enforce it.
module heightmap_triangle_interpolation #(
  parameter int MAX_CELLS = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cell_count,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [12:0]        point_index,
  input  logic signed [15:0] height_value,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] height_out,
  output logic               in_range
);
  import hti_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hti_dp #(
    .MAX_CELLS (MAX_CELLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cell_count),
    .mode         (mode),
    .point_index  (point_index),
    .height_value (height_value),
    .pos_x        (pos_x),
    .pos_z        (pos_z),
    .cmd          (cmd),
    .sts          (sts),
    .height_out   (height_out),
    .in_range     (in_range)
  );

  // one word in flight: accepting makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is still in flight");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input port open while a result word is pending");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (!out_valid && !cmd.sum && !cmd.calc_addr))
    else $error("height write overlaps query commands");

  a_off_grid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_range) |-> (height_out == 16'sd0))
    else $error("off-grid result carries a nonzero height");

endmodule

### test/heightmap_triangle_interpolation_tb.sv
// Self-checking testbench for heightmap_triangle_interpolation: height stores and
// triangle-interpolated queries are predicted in-bench and compared word by word.
// Depends only on the RTL top level; no files or arguments are read.
`timescale 1ns / 100ps

module heightmap_triangle_interpolation_tb;

  localparam int GRID_MAX    = 64;
  localparam int TABLE_DEPTH = (GRID_MAX + 1) * (GRID_MAX + 1);
  localparam int FRAC_BITS   = 8;
  localparam longint UNIT    = longint'(1) << FRAC_BITS;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct {
    logic               mode;
    logic [12:0]        point_index;
    logic signed [15:0] height_value;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;
  } grid_word_t;

  typedef struct {
    logic signed [15:0] height;
    logic               in_range;
  } height_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cell_count = 7'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic [12:0]        point_index = 13'd0;
  logic signed [15:0] height_value = 16'sd0;
  logic signed [15:0] pos_x = 16'sd0;
  logic signed [15:0] pos_z = 16'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] height_out;
  logic               in_range;

  heightmap_triangle_interpolation u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cell_count  (cell_count),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .point_index (point_index),
    .height_value(height_value),
    .pos_x       (pos_x),
    .pos_z       (pos_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .height_out  (height_out),
    .in_range    (in_range)
  );

  // bench-side copy of the block state
  logic signed [15:0] height_mem [TABLE_DEPTH];
  logic [6:0]         grid_cells = 7'd64;
  bit                 planned_set [TABLE_DEPTH];

  grid_word_t   pending_words[$];
  height_word_t expected_heights[$];
  int           queued_cnt = 0;
  int           accepted_cnt = 0;
  int           fail_cnt = 0;
  bit           idle_on = 1'b1;
  logic         in_taken = 1'b0;
  logic         cfg_seen = 1'b0;
  int           gap_left = 0;
  int           stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic height_word_t interp_height(logic signed [15:0] px,
                                                 logic signed [15:0] pz,
                                                 logic [6:0] cfg);
    height_word_t res;
    longint x, z, fx, fz, h0, h1, h2, h3, acc, r;
    int cells, nx, nz, stride, base;
    cells = (cfg > GRID_MAX) ? GRID_MAX : int'(cfg);
    x = longint'(px);
    z = longint'(pz);
    res.height = 16'sd0;
    res.in_range = 1'b0;
    if (x < 0 || z < 0 || (x >>> FRAC_BITS) >= cells || (z >>> FRAC_BITS) >= cells)
      return res;
    nx = int'(x >>> FRAC_BITS);
    nz = int'(z >>> FRAC_BITS);
    fx = x & (UNIT - 1);
    fz = z & (UNIT - 1);
    stride = cells + 1;
    base = nz * stride + nx;
    h0 = longint'(height_mem[base]);
    h1 = longint'(height_mem[base + stride]);
    h2 = longint'(height_mem[base + stride + 1]);
    h3 = longint'(height_mem[base + 1]);
    if (fx + fz < UNIT)
      acc = h1 * UNIT + (h0 - h1) * fz + (h2 - h1) * fx;
    else
      acc = h3 * UNIT + (h2 - h3) * (UNIT - fz) + (h0 - h3) * (UNIT - fx);
    r = (acc + (UNIT >>> 1)) >>> FRAC_BITS;  // floor after half-unit bias
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    res.height = r[15:0];
    res.in_range = 1'b1;
    return res;
  endfunction

  // acceptance tracking and prediction
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall && !rst;
    cfg_seen <= cfg_valid && cfg_ready && !rst;
    if (!rst && cfg_valid && cfg_ready)
      grid_cells = cell_count;
    if (!rst && in_valid && !in_stall) begin
      accepted_cnt++;
      if (mode == MODE_STORE) begin
        if (point_index < TABLE_DEPTH)
          height_mem[point_index] = height_value;
      end else begin
        expected_heights.push_back(interp_height(pos_x, pos_z, grid_cells));
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    grid_word_t w;
    if (in_valid && !in_taken) begin
      // word still stalled: hold it
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_words.size() == 0) begin
      in_valid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(0, 2);
    end else begin
      w = pending_words.pop_front();
      in_valid     <= 1'b1;
      mode         <= w.mode;
      point_index  <= w.point_index;
      height_value <= w.height_value;
      pos_x        <= w.pos_x;
      pos_z        <= w.pos_z;
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    height_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_heights.size() == 0) begin
        $error("unexpected result word: height_out=%0d in_range=%0b", height_out, in_range);
        fail_cnt++;
      end else begin
        want = expected_heights.pop_front();
        if (height_out !== want.height) begin
          $error("height_out mismatch: expected %0d, got %0d", want.height, height_out);
          fail_cnt++;
        end
        if (in_range !== want.in_range) begin
          $error("in_range mismatch: expected %0b, got %0b", want.in_range, in_range);
          fail_cnt++;
        end
      end
    end
  end

  task automatic push_store(input int idx, input logic [15:0] h);
    grid_word_t w;
    w.mode = MODE_STORE;
    w.point_index = idx[12:0];
    w.height_value = h;
    w.pos_x = 16'($urandom_range(0, 65535));
    w.pos_z = 16'($urandom_range(0, 65535));
    pending_words.push_back(w);
    queued_cnt++;
    if (idx < TABLE_DEPTH)
      planned_set[idx] = 1'b1;
  endtask

  task automatic fill_corner(input int idx);
    if (!planned_set[idx])
      push_store(idx, 16'($urandom_range(0, 65535)));
  endtask

  // corners of an on-grid cell are stored first so no unwritten entry is read
  task automatic send_query(input int cells, input logic signed [15:0] px,
                            input logic signed [15:0] pz);
    grid_word_t w;
    int nx, nz, stride, base;
    if (px >= 0 && pz >= 0 && (px >>> FRAC_BITS) < cells && (pz >>> FRAC_BITS) < cells) begin
      nx = int'(px >>> FRAC_BITS);
      nz = int'(pz >>> FRAC_BITS);
      stride = cells + 1;
      base = nz * stride + nx;
      fill_corner(base);
      fill_corner(base + 1);
      fill_corner(base + stride);
      fill_corner(base + stride + 1);
    end
    w.mode = MODE_QUERY;
    w.point_index = 13'($urandom_range(0, 8191));
    w.height_value = 16'($urandom_range(0, 65535));
    w.pos_x = px;
    w.pos_z = pz;
    pending_words.push_back(w);
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (queued_cnt != accepted_cnt || expected_heights.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);  // let a trailing store finish
  endtask

  task automatic set_cells(input logic [6:0] v);
    wait_drained();
    cfg_valid  <= 1'b1;
    cell_count <= v;
    do @(negedge clk); while (!cfg_seen);
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_frac();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 0;
    if (sel == 1) return int'(UNIT) - 1;
    return $urandom_range(0, int'(UNIT) - 1);
  endfunction

  task automatic run_phase(input logic [6:0] v, input int n, input bit gaps);
    int eff, pick, idx;
    logic signed [15:0] px, pz;
    set_cells(v);
    idle_on = gaps;
    eff = (v > GRID_MAX) ? GRID_MAX : v;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        if ($urandom_range(0, 1) == 0 && eff != 0)
          idx = $urandom_range(0, (eff + 1) * (eff + 1) - 1);
        else
          idx = $urandom_range(0, 8191);
        push_store(idx, 16'($urandom_range(0, 65535)));
      end else if (pick < 27 || eff == 0) begin
        px = 16'($urandom_range(0, 65535));
        pz = 16'($urandom_range(0, 65535));
        send_query(eff, px, pz);
      end else begin
        px = 16'($urandom_range(0, eff - 1) * int'(UNIT) + rand_frac());
        pz = 16'($urandom_range(0, eff - 1) * int'(UNIT) + rand_frac());
        send_query(eff, px, pz);
      end
    end
  endtask

  initial begin
    logic signed [15:0] corner_h [9];
    corner_h = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd256, -16'sd256,
                 16'sd1, 16'sh1234, -16'sd1, 16'sd100};
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: 2x2 cells, extreme heights, triangle boundary, grid edges
    set_cells(7'd2);
    for (int i = 0; i < 9; i++)
      push_store(i, corner_h[i]);
    push_store(8191, 16'sh7FFF);            // beyond the table: ignored
    push_store(TABLE_DEPTH, -16'sd32768);
    send_query(2, 16'sh0000, 16'sh0000);
    send_query(2, 16'sh00FF, 16'sh00FF);
    send_query(2, 16'sh0080, 16'sh007F);    // fx+fz just under one
    send_query(2, 16'sh0080, 16'sh0080);    // fx+fz exactly one
    send_query(2, 16'sh01FF, 16'sh01FF);
    send_query(2, 16'sh0180, 16'sh0040);
    send_query(2, 16'sh0200, 16'sh0000);    // x at cell count
    send_query(2, -16'sd1, 16'sh0000);
    send_query(2, 16'sh7FFF, 16'sh7FFF);
    send_query(2, -16'sd32768, -16'sd32768);

    // large grids pull in up to four corner stores per query
    run_phase(7'd0, 20, 1'b1);
    run_phase(7'd1, 60, 1'b1);
    run_phase(7'd3, 70, 1'b1);
    run_phase(7'd64, 35, 1'b0);
    run_phase(7'd127, 20, 1'b1);
    run_phase(7'd4, 70, 1'b1);
    run_phase(7'd7, 70, 1'b1);
    run_phase(7'd100, 20, 1'b1);
    run_phase(7'd2, 60, 1'b1);
    run_phase(7'd16, 45, 1'b0);             // tail runs without idling

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_cnt == 0)
      $display("PASS heightmap_triangle_interpolation");
    else
      $display("FAIL heightmap_triangle_interpolation");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL heightmap_triangle_interpolation");
    $finish;
  end

endmodule
